[sv/keyed_sum_accumulate_table_assert.svh]
// assertion macros for keyed_sum_accumulate_table
// expects clk and rst_n in the including scope
`ifndef KEYED_SUM_ACCUMULATE_TABLE_ASSERT_SVH
`define KEYED_SUM_ACCUMULATE_TABLE_ASSERT_SVH

// generic clocked check, off during reset
`define KSAT_CHECK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("keyed_sum_accumulate_table check failed");

// same-cycle implication
`define KSAT_IMPLIES(label, ante, cons) \
    `KSAT_CHECK(label, ((ante) |-> (cons)))

`endif

[sv/ksat_pkg.sv]
// shared types and constants for keyed_sum_accumulate_table
// no dependencies
`default_nettype none

package ksat_pkg;

    localparam int KEY_W           = 48;
    localparam int AMT_W           = 32;
    localparam int TOTAL_W         = 48;
    localparam int SLOT_W          = 6;
    localparam int ENTRIES_DEFAULT = 64;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [KEY_W-1:0] buyer_key;
        logic [AMT_W-1:0] amount;
    } item_t;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [TOTAL_W-1:0] running_total;
        logic               table_full;
        logic               saturated;
    } result_t;

    // word travelling down the cell row
    typedef struct packed {
        logic               done;
        logic               hit;
        logic               sat;
        logic [KEY_W-1:0]   key;
        logic [AMT_W-1:0]   amount;
        logic [TOTAL_W-1:0] total;
    } flow_t;

endpackage

`default_nettype wire

[sv/keyed_sum_accumulate_table.sv]
// keyed_sum_accumulate_table: group-by-key summing table as a row of entry cells
// depends on ksat_pkg, ksat_cell and keyed_sum_accumulate_table_assert.svh
//
//   channel  | handshake                    | word
//   item     | item_valid / item_stall      | item_data   (ksat_pkg::item_t)
//   result   | result_valid / result_stall  | result_data (ksat_pkg::result_t)
//
// a word enters the row and moves one cell per cycle unless the row is frozen
// the row takes a word every cycle unless stalled; one result per word, in order
// the last cell's register is the result register; when it holds a word that is
// stalled the whole row freezes and item_stall is raised
// reset empties every cell at once, no clearing pass
`default_nettype none

module keyed_sum_accumulate_table #(
    parameter int ENTRIES = ksat_pkg::ENTRIES_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire ksat_pkg::item_t   item_data,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output ksat_pkg::result_t      result_data
);

`include "keyed_sum_accumulate_table_assert.svh"

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic                                   en;
    logic                                   link_valid [ENTRIES+1];
    ksat_pkg::flow_t                        link       [ENTRIES+1];
    logic [IDX_W-1:0]                       link_slot  [ENTRIES+1];
    logic [IDX_W+ksat_pkg::SLOT_W-1:0]      slot_ext;

    assign en         = !(link_valid[ENTRIES] && result_stall);
    assign item_stall = !en;

    always_comb
    begin
        link_valid[0]    = item_valid;
        link[0].done     = 1'b0;
        link[0].hit      = 1'b0;
        link[0].sat      = 1'b0;
        link[0].key      = item_data.buyer_key;
        link[0].amount   = item_data.amount;
        link[0].total    = '0;
        link_slot[0]     = '0;
    end

    for (genvar j = 0; j < ENTRIES; j++)
    begin : g_cell
        ksat_cell #(
            .IDX_W (IDX_W),
            .INDEX (j)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .up_valid   (link_valid[j]),
            .up         (link[j]),
            .up_slot    (link_slot[j]),
            .down_valid (link_valid[j+1]),
            .down       (link[j+1]),
            .down_slot  (link_slot[j+1])
        );
    end

    assign slot_ext = {{ksat_pkg::SLOT_W{1'b0}}, link_slot[ENTRIES]};

    always_comb
    begin
        result_valid              = link_valid[ENTRIES];
        result_data.hit           = link[ENTRIES].hit;
        result_data.slot          = slot_ext[ksat_pkg::SLOT_W-1:0];
        result_data.running_total = link[ENTRIES].total;
        result_data.table_full    = !link[ENTRIES].done;
        result_data.saturated     = link[ENTRIES].sat;
    end

    `KSAT_IMPLIES(a_hit_not_full, result_valid,
        !(result_data.hit && result_data.table_full))
    `KSAT_IMPLIES(a_sat_at_max, result_valid && result_data.saturated,
        result_data.hit && (result_data.running_total == ksat_pkg::TOTAL_MAX))
    `KSAT_IMPLIES(a_full_is_empty, result_valid && result_data.table_full,
        (result_data.running_total == '0) && (result_data.slot == '0)
        && !result_data.saturated)
    `KSAT_IMPLIES(a_row_moves_when_empty, !result_valid, !item_stall)

endmodule

`default_nettype wire

[sv/ksat_cell.sv]
// one table entry plus the pipeline register that hands the word to the next cell
// depends on ksat_pkg
`default_nettype none

module ksat_cell #(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              up_valid,
    input  wire ksat_pkg::flow_t   up,
    input  wire logic [IDX_W-1:0]  up_slot,
    output logic                   down_valid,
    output ksat_pkg::flow_t        down,
    output logic [IDX_W-1:0]       down_slot
);

    logic                            valid_reg;
    logic                            valid_next;
    logic [ksat_pkg::KEY_W-1:0]      key_reg;
    logic [ksat_pkg::KEY_W-1:0]      key_next;
    logic [ksat_pkg::TOTAL_W-1:0]    total_reg;
    logic [ksat_pkg::TOTAL_W-1:0]    total_next;
    logic                            down_valid_reg;
    ksat_pkg::flow_t                 down_reg;
    ksat_pkg::flow_t                 down_next;
    logic [IDX_W-1:0]                slot_reg;
    logic [IDX_W-1:0]                slot_next;

    logic                            live;
    logic                            match;
    logic [ksat_pkg::TOTAL_W:0]      sum;
    logic [ksat_pkg::TOTAL_W-1:0]    clipped;

    always_comb
    begin
        live    = up_valid && !up.done;
        match   = valid_reg && (key_reg == up.key);
        sum     = {1'b0, total_reg} + (ksat_pkg::TOTAL_W + 1)'(up.amount);
        clipped = sum[ksat_pkg::TOTAL_W] ? ksat_pkg::TOTAL_MAX
                                         : sum[ksat_pkg::TOTAL_W-1:0];

        valid_next = valid_reg;
        key_next   = key_reg;
        total_next = total_reg;
        down_next  = up;
        slot_next  = up_slot;

        if (live && match)
        begin
            total_next      = clipped;
            down_next.done  = 1'b1;
            down_next.hit   = 1'b1;
            down_next.sat   = sum[ksat_pkg::TOTAL_W];
            down_next.total = clipped;
            slot_next       = IDX_W'(INDEX);
        end
        else if (live && !valid_reg)
        begin
            // first free entry: append
            valid_next      = 1'b1;
            key_next        = up.key;
            total_next      = ksat_pkg::TOTAL_W'(up.amount);
            down_next.done  = 1'b1;
            down_next.hit   = 1'b0;
            down_next.sat   = 1'b0;
            down_next.total = ksat_pkg::TOTAL_W'(up.amount);
            slot_next       = IDX_W'(INDEX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            down_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg      <= valid_next;
            down_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            key_reg   <= key_next;
            total_reg <= total_next;
            down_reg  <= down_next;
            slot_reg  <= slot_next;
        end
    end

    assign down_valid = down_valid_reg;
    assign down       = down_reg;
    assign down_slot  = slot_reg;

endmodule

`default_nettype wire
